// ===== rtl/core/wildcard_mask_match_top_macros.svh =====
// assertion helpers for the checker file wmm_chk
`ifndef WILDCARD_MASK_MATCH_TOP_MACROS_SVH
`define WILDCARD_MASK_MATCH_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define WMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication: post is checked in the cycle after pre
`define WMM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/wmm_pkg.sv =====
package wmm_pkg;

  // buffer geometry
  localparam int MAX_LEN = 256;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int IW      = LW + 1;

  // special characters
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // request codes
  typedef enum logic [1:0] {
    REQ_MASK = 2'd0,
    REQ_NAME = 2'd1,
    REQ_RUN  = 2'd2
  } req_type_e;

  // match sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_TOP,
    ST_QMARK,
    ST_CMP,
    ST_STAR,
    ST_STAR_Q,
    ST_SCAN,
    ST_SCAN_CHK
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_byte;
  } req_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

  // fold upper case letters to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CH_CASE;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/wmm_ram.sv =====
module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wildcard_mask_match_top.sv =====
// Case-insensitive wildcard matcher over two byte buffers.
// Input: req_i carries a request type and a byte, taken at a clock edge where
// start is high and busy is low. Mask and name bytes are appended one per
// cycle (busy stays low). Bytes beyond the buffer depth are dropped and
// flagged as overflow. A run request raises busy while a small sequencer
// walks both buffers, one mask/name index step per cycle, through the
// registered read ports of the two buffer RAMs. Run time depends on the
// data and grows when the last '*' is retried often.
// The result (matched, overflow) shows on result_o for exactly one cycle with
// result_valid_o, in the cycle where busy has dropped; a new request may be
// taken in that same cycle. The receiver cannot stall the result.
// After each run both buffers are empty and the overflow flag is clear.
// Reset empties both buffers, clears the flag and returns to idle; the RAM
// contents need no reset since reads beyond the stored length return zero.
module wildcard_mask_match_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wmm_pkg::req_t req_i,
  output logic          result_valid_o,
  output wmm_pkg::res_t result_o
);

  wmm_pkg::state_e state_q, state_d;
  logic [wmm_pkg::IW-1:0] m_q, m_d, n_q, n_d;
  logic [wmm_pkg::IW-1:0] star_m_q, star_m_d, star_n_q, star_n_d;
  logic have_star_q, have_star_d;
  logic bt_q, bt_d;
  logic [wmm_pkg::LW-1:0] mlen_q, mlen_d, nlen_q, nlen_d;
  logic drop_q, drop_d;
  logic res_valid_q, res_valid_d;
  wmm_pkg::res_t res_q, res_d;

  logic accept;
  logic mask_we, name_we;
  logic [7:0] mask_rdata, name_rdata;
  logic [7:0] mk, nm, fm, fn;
  logic fin, fin_match;

  assign busy   = (state_q != wmm_pkg::ST_IDLE);
  assign accept = start && !busy;

  // appends go to the buffer tail when there is room
  assign mask_we = accept && (req_i.req_type == wmm_pkg::REQ_MASK)
                   && (mlen_q < wmm_pkg::LW'(wmm_pkg::MAX_LEN));
  assign name_we = accept && (req_i.req_type == wmm_pkg::REQ_NAME)
                   && (nlen_q < wmm_pkg::LW'(wmm_pkg::MAX_LEN));

  // buffer memories, read address follows the next index
  wmm_ram #(
    .WIDTH(8),
    .DEPTH(wmm_pkg::MAX_LEN)
  ) u_mask_ram (
    .clk_i  (clk_i),
    .we_i   (mask_we),
    .waddr_i(mlen_q[wmm_pkg::AW-1:0]),
    .wdata_i(req_i.char_byte),
    .raddr_i(m_d[wmm_pkg::AW-1:0]),
    .rdata_o(mask_rdata)
  );

  wmm_ram #(
    .WIDTH(8),
    .DEPTH(wmm_pkg::MAX_LEN)
  ) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (name_we),
    .waddr_i(nlen_q[wmm_pkg::AW-1:0]),
    .wdata_i(req_i.char_byte),
    .raddr_i(n_d[wmm_pkg::AW-1:0]),
    .rdata_o(name_rdata)
  );

  // characters at the current indexes, zero past the stored length
  assign mk = (m_q < {1'b0, mlen_q}) ? mask_rdata : wmm_pkg::CH_NUL;
  assign nm = (n_q < {1'b0, nlen_q}) ? name_rdata : wmm_pkg::CH_NUL;
  assign fm = wmm_pkg::fold(mk);
  assign fn = wmm_pkg::fold(nm);

  // sequencer: next state, indexes and load bookkeeping
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    n_d         = n_q;
    star_m_d    = star_m_q;
    star_n_d    = star_n_q;
    have_star_d = have_star_q;
    bt_d        = bt_q;
    mlen_d      = mlen_q;
    nlen_d      = nlen_q;
    drop_d      = drop_q;
    fin         = 1'b0;
    fin_match   = 1'b0;

    case (state_q)
      wmm_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            wmm_pkg::REQ_MASK: begin
              if (mask_we) begin
                mlen_d = mlen_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
            wmm_pkg::REQ_NAME: begin
              if (name_we) begin
                nlen_d = nlen_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
            wmm_pkg::REQ_RUN: begin
              m_d         = '0;
              n_d         = '0;
              have_star_d = 1'b0;
              state_d     = wmm_pkg::ST_FIRST;
            end
            default: begin
            end
          endcase
        end
      end

      // first character: a star goes straight to the loop
      wmm_pkg::ST_FIRST: begin
        if (mk == wmm_pkg::CH_STAR) begin
          state_d = wmm_pkg::ST_TOP;
        end else if (mk != wmm_pkg::CH_QMARK && fm != fn) begin
          fin = 1'b1;
        end else begin
          m_d     = m_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_TOP;
        end
      end

      // loop head, dispatch on the mask character
      wmm_pkg::ST_TOP: begin
        if (fm == wmm_pkg::CH_STAR) begin
          m_d     = m_q + 1'b1;
          state_d = wmm_pkg::ST_STAR;
        end else if (fm == wmm_pkg::CH_QMARK) begin
          m_d     = m_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_QMARK;
        end else if (fm == wmm_pkg::CH_BSL) begin
          m_d     = m_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_CMP;
        end else begin
          state_d = wmm_pkg::ST_CMP;
        end
      end

      // single wildcard consumed one name character
      wmm_pkg::ST_QMARK: begin
        if (nm == wmm_pkg::CH_NUL) begin
          fin       = 1'b1;
          fin_match = (mk == wmm_pkg::CH_NUL);
        end else begin
          state_d = wmm_pkg::ST_TOP;
        end
      end

      // literal compare, backtrack to the last star on mismatch (fail if there is none), match at the mask end
      wmm_pkg::ST_CMP: begin
        if (fn != fm) begin
          if (!have_star_q) begin
            fin = 1'b1;
          end else begin
            n_d     = star_n_q + 1'b1;
            m_d     = star_m_q;
            bt_d    = 1'b1;
            state_d = wmm_pkg::ST_SCAN;
          end
        end else if (fm == wmm_pkg::CH_NUL) begin
          fin       = 1'b1;
          fin_match = 1'b1;
        end else begin
          m_d     = m_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_TOP;
        end
      end

      // skip a run of stars and pick the anchor character
      wmm_pkg::ST_STAR: begin
        if (mk == wmm_pkg::CH_NUL) begin
          fin       = 1'b1;
          fin_match = 1'b1;
        end else if (mk == wmm_pkg::CH_STAR) begin
          m_d = m_q + 1'b1;
        end else if (mk == wmm_pkg::CH_BSL) begin
          m_d     = m_q + 1'b1;
          bt_d    = 1'b0;
          state_d = wmm_pkg::ST_SCAN;
        end else if (mk == wmm_pkg::CH_QMARK) begin
          m_d     = m_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_STAR_Q;
        end else begin
          bt_d    = 1'b0;
          state_d = wmm_pkg::ST_SCAN;
        end
      end

      // single wildcards right after a star
      wmm_pkg::ST_STAR_Q: begin
        if (nm == wmm_pkg::CH_NUL) begin
          fin       = 1'b1;
          fin_match = (mk == wmm_pkg::CH_NUL);
        end else if (mk == wmm_pkg::CH_QMARK) begin
          m_d = m_q + 1'b1;
          n_d = n_q + 1'b1;
        end else if (mk == wmm_pkg::CH_NUL) begin
          fin       = 1'b1;
          fin_match = 1'b1;
        end else begin
          bt_d    = 1'b0;
          state_d = wmm_pkg::ST_SCAN;
        end
      end

      // advance the name until it meets the anchor character
      wmm_pkg::ST_SCAN, wmm_pkg::ST_SCAN_CHK: begin
        if (state_q == wmm_pkg::ST_SCAN_CHK && nm == wmm_pkg::CH_NUL) begin
          fin = 1'b1;
        end else if (fn != fm) begin
          n_d     = n_q + 1'b1;
          state_d = wmm_pkg::ST_SCAN_CHK;
        end else if (bt_q) begin
          star_n_d = n_q;
          if (fm == wmm_pkg::CH_NUL) begin
            fin       = 1'b1;
            fin_match = 1'b1;
          end else begin
            m_d     = m_q + 1'b1;
            n_d     = n_q + 1'b1;
            state_d = wmm_pkg::ST_TOP;
          end
        end else begin
          star_m_d    = m_q;
          star_n_d    = n_q;
          have_star_d = 1'b1;
          m_d         = m_q + 1'b1;
          n_d         = n_q + 1'b1;
          state_d     = wmm_pkg::ST_TOP;
        end
      end

      default: begin
        state_d = wmm_pkg::ST_IDLE;
      end
    endcase

    // end of run: report and empty both buffers
    if (fin) begin
      state_d = wmm_pkg::ST_IDLE;
      mlen_d  = '0;
      nlen_d  = '0;
      drop_d  = 1'b0;
    end
  end

  // result register, shown for one cycle
  assign res_valid_d    = fin;
  assign res_d.matched  = fin_match;
  assign res_d.overflow = drop_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmm_pkg::ST_IDLE;
      mlen_q      <= '0;
      nlen_q      <= '0;
      drop_q      <= 1'b0;
      have_star_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mlen_q      <= mlen_d;
      nlen_q      <= nlen_d;
      drop_q      <= drop_d;
      have_star_q <= have_star_d;
      res_valid_q <= res_valid_d;
    end
  end

  // index and result payload registers
  always_ff @(posedge clk_i) begin
    m_q      <= m_d;
    n_q      <= n_d;
    star_m_q <= star_m_d;
    star_n_q <= star_n_d;
    bt_q     <= bt_d;
    if (fin) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/core/wmm_chk.sv =====
`include "wildcard_mask_match_top_macros.svh"

module wmm_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input wmm_pkg::req_t req_i,
  input logic          result_valid_o,
  input wmm_pkg::res_t result_o
);

  logic load_txn, run_txn;

  assign load_txn = start && !busy && (req_i.req_type == wmm_pkg::REQ_MASK ||
                                       req_i.req_type == wmm_pkg::REQ_NAME);
  assign run_txn  = start && !busy && (req_i.req_type == wmm_pkg::REQ_RUN);

  // a run transaction always occupies the matcher
  `WMM_ASSERT_NEXT(a_run_busy, run_txn, busy, "run transaction did not raise busy")

  // appends complete at once and give no result
  `WMM_ASSERT_NEXT(a_load_quiet, load_txn, !busy && !result_valid_o, "append stalled or answered")

  // every run ends with exactly one result strobe
  `WMM_ASSERT(a_end_strobe, $fell(busy) |-> result_valid_o, "run ended without a result")

  // a result only follows a busy period
  `WMM_ASSERT(a_strobe_src, result_valid_o |-> $past(busy) && !busy, "result outside a run")

  // results last a single cycle
  `WMM_ASSERT_NEXT(a_strobe_len, result_valid_o, !result_valid_o, "result strobe too long")

endmodule

bind wildcard_mask_match_top wmm_chk u_wmm_chk (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wmm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 600;

  typedef logic [7:0] byte_queue_t [$];

  // glob match predictor and expected result store
  class match_scoreboard;
    logic [7:0] mask_mem [MAX_LEN];
    logic [7:0] name_mem [MAX_LEN];
    int mask_len;
    int name_len;
    bit dropped;
    res_t expected_q [$];
    int fail_count;
    int run_count;
    int match_count;
    int oflow_count;

    function logic [7:0] fold_ch(logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CH_CASE) : c;
    endfunction

    // bytes past the stored length read as string end
    function logic [7:0] mask_at(int unsigned i);
      return (i < mask_len) ? mask_mem[i] : CH_NUL;
    endfunction

    function logic [7:0] name_at(int unsigned i);
      return (i < name_len) ? name_mem[i] : CH_NUL;
    endfunction

    // wildcard match, only the latest star is retried
    function bit predict_match();
      int unsigned m;
      int unsigned n;
      int unsigned star_m;
      int unsigned star_n;
      bit have_star;
      logic [7:0] cm;
      m = 0;
      n = 0;
      star_m = 0;
      star_n = 0;
      have_star = 1'b0;
      cm = mask_at(0);
      // first character: a leading backslash is literal here
      if (cm == CH_STAR) begin
        if (mask_at(1) == CH_NUL) return 1'b1;
      end else if (cm != CH_QMARK && fold_ch(cm) != fold_ch(name_at(0))) begin
        return 1'b0;
      end else begin
        m++;
        n++;
      end
      cm = fold_ch(mask_at(m));
      forever begin
        if (cm == CH_STAR) begin
          m++;
          if (mask_at(m) == CH_NUL) return 1'b1;
          while (mask_at(m) == CH_STAR) begin
            m++;
            if (mask_at(m) == CH_NUL) return 1'b1;
          end
          cm = mask_at(m);
          if (cm == CH_BSL) begin
            m++;
            cm = mask_at(m);
          end else if (cm == CH_QMARK) begin
            do begin
              m++;
              n++;
              if (name_at(n) == CH_NUL) return mask_at(m) == CH_NUL;
            end while (mask_at(m) == CH_QMARK);
            cm = mask_at(m);
            if (cm == CH_NUL) return 1'b1;
          end
          cm = fold_ch(cm);
          // scan the name for the character after the star
          while (fold_ch(name_at(n)) != cm) begin
            n++;
            if (name_at(n) == CH_NUL) return 1'b0;
          end
          star_m = m;
          have_star = 1'b1;
          m++;
          cm = fold_ch(mask_at(m));
          star_n = n;
          n++;
          continue;
        end
        if (cm == CH_QMARK) begin
          m++;
          cm = fold_ch(mask_at(m));
          n++;
          if (name_at(n) == CH_NUL) return cm == CH_NUL;
          continue;
        end
        if (cm == CH_BSL) begin
          m++;
          cm = fold_ch(mask_at(m));
          n++;
        end
        // mismatch: retry from the latest star one name byte further
        if (fold_ch(name_at(n)) != cm) begin
          if (!have_star) return 1'b0;
          n = star_n + 1;
          m = star_m;
          cm = fold_ch(mask_at(m));
          while (cm != fold_ch(name_at(n))) begin
            n++;
            if (name_at(n) == CH_NUL) return 1'b0;
          end
          star_n = n;
        end
        if (cm == CH_NUL) return 1'b1;
        m++;
        n++;
        cm = fold_ch(mask_at(m));
      end
    endfunction

    // update buffers for an accepted transaction
    function void note_request(req_t r);
      res_t exp_res;
      case (r.req_type)
        REQ_MASK: begin
          if (mask_len < MAX_LEN) mask_mem[mask_len++] = r.char_byte;
          else dropped = 1'b1;
        end
        REQ_NAME: begin
          if (name_len < MAX_LEN) name_mem[name_len++] = r.char_byte;
          else dropped = 1'b1;
        end
        REQ_RUN: begin
          exp_res.matched = predict_match();
          exp_res.overflow = dropped;
          expected_q.push_back(exp_res);
          mask_len = 0;
          name_len = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // compare one result with the oldest expectation
    function void check_result(res_t got);
      res_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, got matched=%0b overflow=%0b",
                 $time, got.matched, got.overflow);
        fail_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      run_count++;
      if (exp_res.matched) match_count++;
      if (exp_res.overflow) oflow_count++;
      if (got.matched !== exp_res.matched) begin
        $display("%0t: matched mismatch, expected %0b, got %0b",
                 $time, exp_res.matched, got.matched);
        fail_count++;
      end
      if (got.overflow !== exp_res.overflow) begin
        $display("%0t: overflow mismatch, expected %0b, got %0b",
                 $time, exp_res.overflow, got.overflow);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic result_valid_o;
  res_t result_o;

  match_scoreboard sb;
  int idle_pct;
  int items_sent;
  int unsigned cycle_cnt;

  wildcard_mask_match_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("wildcard_mask_match_top test failed");
      $finish;
    end
  end

  // monitor: results first, then accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  // drive one transaction, with an optional gap before it
  task automatic send_req(input logic [1:0] kind, input logic [7:0] ch);
    // each cycle idles with the phase percentage
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= {kind, ch};
    do @(posedge clk_i); while (busy);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // hold off until every expected result is back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // load both strings in random interleave, then run
  task automatic run_set(input byte_queue_t mk, input byte_queue_t nm);
    int mi;
    int ni;
    mi = 0;
    ni = 0;
    while (mi < mk.size() || ni < nm.size()) begin
      if (ni >= nm.size() || (mi < mk.size() && $urandom_range(0, 1) == 1)) begin
        send_req(REQ_MASK, mk[mi]);
        mi++;
      end else begin
        send_req(REQ_NAME, nm[ni]);
        ni++;
      end
    end
    if ($urandom_range(0, 19) == 0) send_req(REQ_UNUSED, 8'($urandom_range(0, 255)));
    send_req(REQ_RUN, 8'($urandom_range(0, 255)));
  endtask

  function automatic byte_queue_t str2q(string s);
    byte_queue_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // name characters: few letters, case edges, wildcards, any nonzero byte
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 2));
      3, 4, 5: return 8'h41 + 8'($urandom_range(0, 2));
      6: begin
        case ($urandom_range(0, 2))
          0: return CH_STAR;
          1: return CH_QMARK;
          default: return CH_BSL;
        endcase
      end
      7: return 8'($urandom_range(1, 255));
      default: begin
        case ($urandom_range(0, 7))
          0: return 8'h40;
          1: return 8'h41;
          2: return 8'h5a;
          3: return 8'h5b;
          4: return 8'h60;
          5: return 8'h61;
          6: return 8'h7a;
          default: return 8'h7b;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_mask_char();
    case ($urandom_range(0, 9))
      0, 1: return CH_STAR;
      2: return CH_QMARK;
      3: return CH_BSL;
      default: return pick_char();
    endcase
  endfunction

  // mask built from the name so most sets get deep into the match
  function automatic void make_wellformed(output byte_queue_t mk, output byte_queue_t nm);
    int len;
    int i;
    int r;
    logic [7:0] c;
    mk = {};
    nm = {};
    len = $urandom_range(0, 10);
    for (int k = 0; k < len; k++) nm.push_back(pick_char());
    i = 0;
    while (i < nm.size()) begin
      r = $urandom_range(0, 99);
      c = nm[i];
      if (r < 45) begin
        if ((c | CH_CASE) >= 8'h61 && (c | CH_CASE) <= 8'h7a && $urandom_range(0, 1) == 1)
          c = c ^ CH_CASE;
        mk.push_back(c);
        i++;
      end else if (r < 60) begin
        mk.push_back(CH_QMARK);
        i++;
      end else if (r < 75) begin
        mk.push_back(CH_STAR);
        i += $urandom_range(0, 3);
      end else if (r < 85) begin
        mk.push_back(CH_BSL);
        mk.push_back(c);
        i++;
      end else begin
        mk.push_back(c);
        i++;
      end
    end
    if ($urandom_range(0, 4) == 0) mk.push_back(CH_STAR);
    // break some of them
    if ($urandom_range(0, 3) == 0) begin
      if (mk.size() > 0) mk[$urandom_range(0, mk.size() - 1)] = pick_mask_char();
      else nm.push_back(pick_char());
    end
  endfunction

  function automatic void make_pair(output byte_queue_t mk, output byte_queue_t nm);
    int r;
    int mlen;
    int nlen;
    mk = {};
    nm = {};
    r = $urandom_range(0, 99);
    if (r < 2) begin
      // buffers around full, some past it
      mlen = $urandom_range(0, 1) ? $urandom_range(254, 259) : 2;
      nlen = $urandom_range(254, 259);
      if (mlen == 2) begin
        mk.push_back(CH_STAR);
        mk.push_back(8'h78);
      end else begin
        for (int k = 0; k < mlen; k++) mk.push_back($urandom_range(0, 1) ? 8'h78 : 8'h58);
      end
      for (int k = 0; k < nlen; k++) nm.push_back($urandom_range(0, 1) ? 8'h78 : 8'h58);
    end else if (r < 72) begin
      make_wellformed(mk, nm);
    end else if (r < 90) begin
      mlen = $urandom_range(0, 8);
      nlen = $urandom_range(0, 8);
      for (int k = 0; k < mlen; k++) mk.push_back(pick_mask_char());
      for (int k = 0; k < nlen; k++) nm.push_back(pick_char());
    end else begin
      mlen = $urandom_range(0, 6);
      nlen = $urandom_range(0, 6);
      for (int k = 0; k < mlen; k++) mk.push_back(8'($urandom_range(0, 255)));
      for (int k = 0; k < nlen; k++) nm.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    byte_queue_t mk;
    byte_queue_t nm;
    int base;
    sb = new();
    idle_pct = 36;
    items_sent = 0;
    cycle_cnt = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty strings, lone star, case folding, escapes
    run_set(str2q(""), str2q(""));
    run_set(str2q("*"), str2q(""));
    run_set(str2q("A?c"), str2q("abC"));
    run_set(str2q("\\a"), str2q("\\A"));
    run_set(str2q("a\\*b"), str2q("a*b"));
    // zero byte ends the mask early
    mk = {8'h61, CH_NUL, 8'h62};
    nm = {8'h61};
    run_set(mk, nm);
    // top byte value plus an ignored request code
    mk = {8'hff};
    nm = {8'hff};
    send_req(REQ_UNUSED, 8'hff);
    run_set(mk, nm);
    drain();

    // random sets in three idling phases
    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 36 : (ph == 1) ? 55 : 0;
      while (items_sent < base + (ph + 1) * RANDOM_PER_PHASE) begin
        make_pair(mk, nm);
        run_set(mk, nm);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("checked %0d match runs, %0d matched and %0d with dropped bytes",
             sb.run_count, sb.match_count, sb.oflow_count);
    $display("over %0d load and run requests in %0d cycles", items_sent, cycle_cnt);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("wildcard_mask_match_top test passed");
    end else begin
      $display("wildcard_mask_match_top test failed");
    end
    $finish;
  end

endmodule

// ===== wildcard_mask_match_top.f =====
+incdir+rtl/core
rtl/core/wmm_pkg.sv
rtl/core/wmm_ram.sv
rtl/core/wildcard_mask_match_top.sv
rtl/core/wmm_chk.sv
bench/tb.sv
